### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ready queue checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPRQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TPRQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tprq_pkg.sv
// ---------------------------------------------------------------------------
// Ready queue package
// Opcodes, status codes and the stored entry type of the ready queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tprq_pkg;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int ENTRY_W = 16;

  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] prio;
  } entry_t;

endpackage

`default_nettype wire

### sv/tprq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tprq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/task_ready_priority_queue_core.sv
// ---------------------------------------------------------------------------
// Task ready priority queue
// Ready queue of a cooperative scheduler, kept sorted by descending priority.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one beat per request: opcode
// enqueue inserts task_id with prio behind all waiting tasks of equal
// priority; opcode dispatch pops the highest-priority task. Every beat gives
// exactly one result beat on the output channel (out_valid/out_stall) with
// status, the popped task, the fill level and an idle flag.
// Entries sit in a circular buffer in one RAM. An insert walks from the tail
// toward the head, one entry per cycle, moving each lower-priority entry up
// one slot; the RAM read/write port pair sets that pace.
// Dispatch reads the head, then runs S_POP and S_OUT; enqueue goes to S_OUT
// when full or empty, else S_INS per entry read, S_PUT if all moved, S_OUT.
// in_stall is high from accept until the result is handed to the output
// register; a result waiting on out_stall does not block the next accept,
// but that item's result waits until the output register drains.
// Reset empties the queue at once; no clearing pass runs.
// ---------------------------------------------------------------------------
`default_nettype none

module task_ready_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] task_id,
  input  wire logic [7:0] prio,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic            run_valid,
  output logic [7:0]      run_task,
  output logic [7:0]      run_prio,
  output logic [4:0]      ready_count,
  output logic            idle
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [2:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] rp, rp_next;
  logic [CW-1:0] rem, rem_next;
  tprq_pkg::entry_t new_ent, new_ent_next;
  logic [1:0]    res_status, res_status_next;
  logic          res_run, res_run_next;
  tprq_pkg::entry_t res_ent, res_ent_next;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [tprq_pkg::ENTRY_W-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [tprq_pkg::ENTRY_W-1:0] ram_rd_data;
  tprq_pkg::entry_t rd_ent;

  logic          out_load;
  logic [CW+4:0] count_wide;

  tprq_ram #(
    .WIDTH(tprq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign rd_ent     = tprq_pkg::entry_t'(ram_rd_data);
  assign in_stall   = (state != S_IDLE);
  assign out_load   = (state == S_OUT) && (!out_valid || !out_stall);
  assign count_wide = (CW + 5)'(count);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    wp_next         = wp;
    rp_next         = rp;
    rem_next        = rem;
    new_ent_next    = new_ent;
    res_status_next = res_status;
    res_run_next    = res_run;
    res_ent_next    = res_ent;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = wp;
    ram_wr_data     = new_ent;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = rp;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          new_ent_next.task_id = task_id;
          new_ent_next.prio    = prio;
          res_status_next      = tprq_pkg::ST_OK;
          res_run_next         = 1'b0;
          res_ent_next         = '0;
          if (opcode == tprq_pkg::OP_ENQUEUE) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              res_status_next = tprq_pkg::ST_FULL;
              state_next      = S_OUT;
            end else if (count == '0) begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = tail;
              ram_wr_data = {task_id, prio};
              tail_next   = ptr_inc(tail);
              count_next  = count + 1'b1;
              state_next  = S_OUT;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = ptr_dec(tail);
              rp_next     = ptr_dec(tail);
              wp_next     = tail;
              rem_next    = count;
              tail_next   = ptr_inc(tail);
              count_next  = count + 1'b1;
              state_next  = S_INS;
            end
          end else begin
            if (count == '0) begin
              res_status_next = tprq_pkg::ST_EMPTY;
              state_next      = S_OUT;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = head;
              state_next  = S_POP;
            end
          end
        end
      end
      S_INS: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = wp;
        if (rd_ent.prio < new_ent.prio) begin
          ram_wr_data = ram_rd_data;
          wp_next     = rp;
          rem_next    = rem - 1'b1;
          if (rem == CW'(1)) begin
            state_next = S_PUT;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_dec(rp);
            rp_next     = ptr_dec(rp);
          end
        end else begin
          ram_wr_data = new_ent;
          state_next  = S_OUT;
        end
      end
      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = wp;
        ram_wr_data = new_ent;
        state_next  = S_OUT;
      end
      S_POP: begin
        res_run_next = 1'b1;
        res_ent_next = rd_ent;
        head_next    = ptr_inc(head);
        count_next   = count - 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wp         <= wp_next;
    rp         <= rp_next;
    rem        <= rem_next;
    new_ent    <= new_ent_next;
    res_status <= res_status_next;
    res_run    <= res_run_next;
    res_ent    <= res_ent_next;
    if (out_load) begin
      status      <= res_status;
      run_valid   <= res_run;
      run_task    <= res_ent.task_id;
      run_prio    <= res_ent.prio;
      ready_count <= count_wide[4:0];
      idle        <= (count == '0);
    end
  end

endmodule

`default_nettype wire

### sv/tprq_checker.sv
// ---------------------------------------------------------------------------
// Ready queue checker
// Port-level assertions on result beats of the ready queue.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tprq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status,
  input wire logic       run_valid,
  input wire logic [7:0] run_task,
  input wire logic [7:0] run_prio,
  input wire logic [4:0] ready_count,
  input wire logic       idle
);

  `TPRQ_ASSERT_IMP(a_run_ok, clk, rst, out_valid && run_valid,
                   status == tprq_pkg::ST_OK, "run without ok status")
  `TPRQ_ASSERT_IMP(a_norun_zero, clk, rst, out_valid && !run_valid,
                   run_task == 8'd0 && run_prio == 8'd0, "idle result carries a task")
  `TPRQ_ASSERT_IMP(a_empty_idle, clk, rst, out_valid && status == tprq_pkg::ST_EMPTY,
                   idle && ready_count == 5'd0 && !run_valid, "empty dispatch not idle")
  `TPRQ_ASSERT_IMP(a_full_busy, clk, rst, out_valid && status == tprq_pkg::ST_FULL,
                   !idle && !run_valid, "full drop reports idle")
  `TPRQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(status) && $stable(run_task), "stalled result changed")

endmodule

bind task_ready_priority_queue_core tprq_checker u_tprq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .run_valid  (run_valid),
  .run_task   (run_task),
  .run_prio   (run_prio),
  .ready_count(ready_count),
  .idle       (idle)
);

`default_nettype wire
